### src/bbds_pkg.sv
// ----------------------------------------------------------------------------
// bbds_pkg
// Shared widths, defaults, register codes and status codes for the burst birth/death
// scheduler.
// ----------------------------------------------------------------------------
package bbds_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF   = 48;

  localparam int RATE_W     = 24;
  localparam int CPS_W      = 32;
  localparam int FIELD_T_W  = 48;
  localparam int GAP_W      = 32;
  localparam int LEN_W      = 32;
  localparam int ACTIVE_W   = 7;
  localparam int INTERVAL_W = 32;
  localparam int STATUS_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // in: current_time, birth_gap, burst_length -> 112 bits
  localparam int IN_TDATA_W  = 112;
  // out: active_bursts, next_is_birth, event time, packet_interval,
  // status -> 90 bits, padded to 96
  localparam int OUT_TDATA_W = 96;

  localparam logic [RATE_W-1:0]    PACKET_RATE_RST = 24'd1000;
  localparam logic [CPS_W-1:0]     CPS_RST         = 32'd1000000000;
  localparam logic [FIELD_T_W-1:0] END_TIME_RST    = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACKET_RATE       = 2'd0,
    REG_CYCLES_PER_SECOND = 2'd1,
    REG_END_TIME          = 2'd2
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_QUEUE_FULL = 2'd1,
    ST_NONE_DEATH = 2'd2
  } status_t;

endpackage

### src/burst_birth_death_scheduler.sv
// ----------------------------------------------------------------------------
// burst_birth_death_scheduler
// Birth/death event scheduler for bursty traffic. Burst end times sit in a
// sorted ring in RAM; births walk it from the tail, deaths pop the head.
//
//   channel  dir  handshake          payload
//   in_*     in   tvalid/tready      current_time, birth_gap, burst_length
//   out_*    out  tvalid/tready      count, next kind/time, interval, status
//   cfg_*    in   we (no wait)       packet_rate, cycles_per_second, end_time
//
// One item at a time. A birth walks the queued end times that are not below
// the new one, one entry per cycle on the RAM read port, and every item then
// runs the 32-step divider. The next item is taken while a result waits in
// the output register. Reset is synchronous; the RAM is not cleared.
// ----------------------------------------------------------------------------
module burst_birth_death_scheduler #(
  parameter int QUEUE_DEPTH = bbds_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = bbds_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: current_time[47:0], birth_gap[79:48], burst_length[111:80]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bbds_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: active_bursts[6:0], next_is_birth[7], event time[55:8],
  // packet_interval[87:56], status[89:88], zero pad[95:90]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bbds_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [bbds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbds_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bbds_pkg::*;

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int SUM_W  = CNT_W + 1;
  localparam int TB     = TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_NBT, S_END, S_QUEUE, S_INS_CMP, S_INS_PUT,
    S_DEATH, S_HEAD, S_PICK, S_DIV, S_DONE
  } state_t;

  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
                                            input logic [31:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + (TB+1)'(b);
    return s[TB] ? {TB{1'b1}} : s[TB-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : p - ADDR_W'(1);
  endfunction

  state_t                state_r;
  logic [RATE_W-1:0]     packet_rate_r;
  logic [CPS_W-1:0]      cps_r;
  logic [FIELD_T_W-1:0]  end_time_r;

  logic [ADDR_W-1:0]     head_r;
  logic [CNT_W-1:0]      count_r;
  logic [TB-1:0]         nbt_r;
  logic                  pending_r;

  logic [TB-1:0]         now_r;
  logic [GAP_W-1:0]      gap_r;
  logic [LEN_W-1:0]      len_r;
  logic [TB-1:0]         t_r;
  logic [ADDR_W-1:0]     p_r;
  logic [ADDR_W-1:0]     j_r;
  status_t               status_r;
  logic                  birth_next_r;
  logic [TB-1:0]         next_t_r;

  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [TB-1:0]         ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [TB-1:0]         ram_q;

  logic                  div_start;
  logic                  div_done;
  logic [INTERVAL_W-1:0] div_quot;

  logic [SUM_W-1:0]      tail_sum;
  logic [ADDR_W-1:0]     p_init;
  logic                  shift_up;
  logic [63:0]           in_now64;
  logic [63:0]           end64;
  logic [TB-1:0]         end_tb;
  logic                  pick_birth;
  logic [TB-1:0]         pick_t0;
  logic [TB-1:0]         pick_t;
  logic [63:0]           next64;
  logic [INTERVAL_W-1:0] interval;

  bbds_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .WIDTH  (TB),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  bbds_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rate     (packet_rate_r),
    .count    (count_r),
    .dividend (cps_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    tail_sum = SUM_W'(head_r) + SUM_W'(count_r) - SUM_W'(1);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    p_init   = tail_sum[ADDR_W-1:0];
    shift_up = (ram_q >= t_r);

    in_now64 = 64'(in_tdata[FIELD_T_W-1:0]);
    end64    = 64'(end_time_r);
    end_tb   = end64[TB-1:0];

    if (count_r == '0) begin
      pick_birth = 1'b1;
      pick_t0    = nbt_r;
    end else begin
      pick_birth = (nbt_r < ram_q);
      pick_t0    = (ram_q < nbt_r) ? ram_q : nbt_r;
    end
    pick_t   = (end_tb < pick_t0) ? end_tb : pick_t0;

    next64   = 64'(next_t_r);
    interval = (count_r == '0) ? '0 : div_quot;
  end

  // RAM port control and divider start
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_inc(p_r);
    ram_wdata = ram_q;
    ram_re    = 1'b0;
    ram_raddr = p_r;
    div_start = 1'b0;
    case (state_r)
      S_QUEUE: begin
        if (count_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = head_r;
          ram_wdata = t_r;
        end else if (count_r < CNT_W'(QUEUE_DEPTH)) begin
          ram_re    = 1'b1;
          ram_raddr = p_init;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (shift_up) begin
          if (j_r != '0) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec(p_r);
          end
        end else begin
          ram_wdata = t_r;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        ram_wdata = t_r;
      end
      S_HEAD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      packet_rate_r <= PACKET_RATE_RST;
      cps_r         <= CPS_RST;
      end_time_r    <= END_TIME_RST;
      head_r        <= '0;
      count_r       <= '0;
      nbt_r         <= '0;
      pending_r     <= 1'b1;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PACKET_RATE:       packet_rate_r <= cfg_wdata[RATE_W-1:0];
          REG_CYCLES_PER_SECOND: cps_r         <= cfg_wdata[CPS_W-1:0];
          REG_END_TIME:          end_time_r    <= cfg_wdata[FIELD_T_W-1:0];
          default: ;
        endcase
      end

      // S_DONE loads the output register itself
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            now_r    <= in_now64[TB-1:0];
            gap_r    <= in_tdata[FIELD_T_W +: GAP_W];
            len_r    <= in_tdata[FIELD_T_W+GAP_W +: LEN_W];
            status_r <= ST_OK;
            state_r  <= pending_r ? S_NBT : S_DEATH;
          end
        end
        S_NBT: begin
          nbt_r   <= sat_add(now_r, gap_r);
          state_r <= S_END;
        end
        S_END: begin
          t_r     <= sat_add(nbt_r, len_r);
          state_r <= S_QUEUE;
        end
        S_QUEUE: begin
          if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
            status_r <= ST_QUEUE_FULL;
            state_r  <= S_HEAD;
          end else if (count_r == '0) begin
            count_r <= count_r + CNT_W'(1);
            state_r <= S_HEAD;
          end else begin
            p_r     <= p_init;
            j_r     <= ADDR_W'(count_r - CNT_W'(1));
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (shift_up) begin
            if (j_r == '0) begin
              state_r <= S_INS_PUT;
            end else begin
              p_r <= ptr_dec(p_r);
              j_r <= j_r - ADDR_W'(1);
            end
          end else begin
            count_r <= count_r + CNT_W'(1);
            state_r <= S_HEAD;
          end
        end
        S_INS_PUT: begin
          count_r <= count_r + CNT_W'(1);
          state_r <= S_HEAD;
        end
        S_DEATH: begin
          if (count_r == '0) begin
            status_r <= ST_NONE_DEATH;
          end else begin
            head_r  <= ptr_inc(head_r);
            count_r <= count_r - CNT_W'(1);
          end
          state_r <= S_HEAD;
        end
        S_HEAD: begin
          state_r <= S_PICK;
        end
        S_PICK: begin
          birth_next_r <= pick_birth;
          next_t_r     <= pick_t;
          pending_r    <= pick_birth;
          state_r      <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{(OUT_TDATA_W-90){1'b0}},
                             status_r,
                             interval,
                             next64[FIELD_T_W-1:0],
                             birth_next_r,
                             ACTIVE_W'(count_r)};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### src/bbds_ram.sv
// ----------------------------------------------------------------------------
// bbds_ram
// Simple dual-port RAM for the end-time ring: one write, one registered read.
// ----------------------------------------------------------------------------
module bbds_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/bbds_div.sv
// ----------------------------------------------------------------------------
// bbds_div
// Packet interval unit: registered rate * count, then a restoring divide,
// one quotient bit per cycle. Zero divisor gives all ones.
// ----------------------------------------------------------------------------
module bbds_div #(
  parameter int CNT_W = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [bbds_pkg::RATE_W-1:0]     rate,
  input  logic [CNT_W-1:0]                count,
  input  logic [bbds_pkg::CPS_W-1:0]      dividend,
  output logic                            done,
  output logic [bbds_pkg::INTERVAL_W-1:0] quot
);
  import bbds_pkg::*;

  localparam int PW    = RATE_W + CNT_W;
  localparam int BIT_W = $clog2(CPS_W);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} dstate_t;

  dstate_t          st_r;
  logic             done_r;
  logic [PW-1:0]    dvs_r;
  logic [PW-1:0]    rem_r;
  logic [CPS_W-1:0] q_r;
  logic [BIT_W-1:0] bit_r;

  logic [PW:0]      trial;
  logic             take;
  logic [PW:0]      diff;

  always_comb begin
    trial = {rem_r, q_r[CPS_W-1]};
    take  = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      unique case (st_r)
        D_IDLE: begin
          if (start) begin
            dvs_r  <= PW'(rate) * PW'(count);
            q_r    <= dividend;
            rem_r  <= '0;
            bit_r  <= BIT_W'(CPS_W - 1);
            done_r <= 1'b0;
            st_r   <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (dvs_r == '0) begin
            q_r    <= '1;
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end else begin
            st_r <= D_RUN;
          end
        end
        D_RUN: begin
          q_r   <= {q_r[CPS_W-2:0], take};
          rem_r <= take ? diff[PW-1:0] : trial[PW-1:0];
          bit_r <= bit_r - BIT_W'(1);
          if (bit_r == '0) begin
            done_r <= 1'b1;
            st_r   <= D_IDLE;
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = INTERVAL_W'(q_r);

endmodule

### src/bbds_checker.sv
// ----------------------------------------------------------------------------
// bbds_checker
// Port-level checks for the burst birth/death scheduler, bound to the top.
// ----------------------------------------------------------------------------
module bbds_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bbds_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bbds_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item in flight: no back-to-back accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[89:88] != 2'b11)
    else $error("undefined status code");

  // death on an empty queue leaves nothing active: zero interval, birth next
  a_empty_death: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[89:88] == ST_NONE_DEATH |->
      out_tdata[87:56] == '0 && out_tdata[7])
    else $error("empty death result inconsistent");

endmodule

bind burst_birth_death_scheduler bbds_checker u_bbds_checker (.*);

### dv/burst_birth_death_scheduler_tb.sv
// ----------------------------------------------------------------------------
// burst_birth_death_scheduler_tb
// Self-checking bench for the burst birth/death scheduler. Event items go in
// over the in_* stream and result items come back over out_* while both
// sides idle at random. A scoreboard model of the sorted end-time queue
// predicts each result, and every result is compared field by field. The
// first part is directed: time saturation, equal times, end_time clamping,
// a zero packet rate and masked register writes. The random traffic that
// follows mostly tracks the scheduled event time. It fills the queue to
// overflow and drains it again, across several register settings and
// idling mixes, including a long output stall.
// ----------------------------------------------------------------------------
module burst_birth_death_scheduler_tb;
  import bbds_pkg::*;

  localparam int DEPTH         = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int PHASE_ITEMS   = 300;
  localparam logic [FIELD_T_W-1:0] T_MAX = '1;

  typedef struct packed {
    logic [LEN_W-1:0]     burst_length;
    logic [GAP_W-1:0]     birth_gap;
    logic [FIELD_T_W-1:0] current_time;
  } sched_event_t;

  typedef struct {
    logic [ACTIVE_W-1:0]   active_bursts;
    logic                  next_is_birth;
    logic [FIELD_T_W-1:0]  event_time;
    logic [INTERVAL_W-1:0] packet_interval;
    status_t               status;
  } sched_result_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // scoreboard model state
  logic [FIELD_T_W-1:0]  end_q[$];
  logic [FIELD_T_W-1:0]  birth_due;
  logic                  birth_pending;
  logic [RATE_W-1:0]     rate_cfg;
  logic [CPS_W-1:0]      cps_cfg;
  logic [FIELD_T_W-1:0]  end_cfg;
  logic [FIELD_T_W-1:0]  sched_now;

  sched_result_t result_q[$];
  int err_count   = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold     = 0;

  burst_birth_death_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random idling plus an optional long hold-off
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $error("result item with none expected");
        err_count++;
      end else begin
        want = result_q.pop_front();
        if (out_tdata[6:0] !== want.active_bursts) begin
          $error("active_bursts: expected %0d, got %0d", want.active_bursts, out_tdata[6:0]);
          err_count++;
        end
        if (out_tdata[7] !== want.next_is_birth) begin
          $error("next_is_birth: expected %0d, got %0d", want.next_is_birth, out_tdata[7]);
          err_count++;
        end
        if (out_tdata[55:8] !== want.event_time) begin
          $error("event_time: expected %0h, got %0h", want.event_time,
                 out_tdata[55:8]);
          err_count++;
        end
        if (out_tdata[87:56] !== want.packet_interval) begin
          $error("packet_interval: expected %0d, got %0d", want.packet_interval,
                 out_tdata[87:56]);
          err_count++;
        end
        if (out_tdata[89:88] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[89:88]);
          err_count++;
        end
      end
    end
  end

  function automatic logic [FIELD_T_W-1:0] sat_time(input logic [FIELD_T_W-1:0] a,
                                                    input logic [FIELD_T_W-1:0] b);
    logic [FIELD_T_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FIELD_T_W] ? T_MAX : s[FIELD_T_W-1:0];
  endfunction

  function automatic sched_result_t predict_event(input sched_event_t ev);
    sched_result_t r;
    logic [FIELD_T_W-1:0] end_t;
    logic [FIELD_T_W-1:0] next_t;
    logic [63:0] divisor;
    logic [63:0] quot;
    int pos;
    r.status = ST_OK;
    if (birth_pending) begin
      birth_due = sat_time(ev.current_time, FIELD_T_W'(ev.birth_gap));
      if (end_q.size() >= DEPTH) begin
        r.status = ST_QUEUE_FULL;
      end else begin
        end_t = sat_time(birth_due, FIELD_T_W'(ev.burst_length));
        pos = 0;
        // new end time lands ahead of equal ones
        while (pos < end_q.size() && end_q[pos] < end_t) pos++;
        end_q.insert(pos, end_t);
      end
    end else if (end_q.size() == 0) begin
      r.status = ST_NONE_DEATH;
    end else begin
      void'(end_q.pop_front());
    end

    next_t = birth_due;
    if (end_q.size() == 0) begin
      r.next_is_birth = 1'b1;
    end else begin
      r.next_is_birth = (birth_due < end_q[0]);
      if (end_q[0] < next_t) next_t = end_q[0];
    end
    if (end_cfg < next_t) next_t = end_cfg;
    birth_pending = r.next_is_birth;

    r.active_bursts   = ACTIVE_W'(end_q.size());
    r.event_time      = next_t;
    if (end_q.size() == 0) begin
      r.packet_interval = '0;
    end else begin
      divisor = 64'(rate_cfg) * 64'(end_q.size());
      if (divisor == 0) begin
        r.packet_interval = '1;
      end else begin
        quot = 64'(cps_cfg) / divisor;
        r.packet_interval = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
      end
    end
    sched_now = next_t;
    return r;
  endfunction

  function automatic sched_event_t make_event(input logic [FIELD_T_W-1:0] now,
                                              input logic [GAP_W-1:0] gap,
                                              input logic [LEN_W-1:0] len);
    sched_event_t ev;
    ev.current_time = now;
    ev.birth_gap    = gap;
    ev.burst_length = len;
    return ev;
  endfunction

  function automatic logic [FIELD_T_W-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[FIELD_T_W-1:0];
  endfunction

  // random 32-bit value of a random bit length within lo..hi
  function automatic logic [31:0] rand_scaled(input int lo, input int hi);
    logic [63:0] m;
    m = (64'd1 << $urandom_range(hi, lo)) - 64'd1;
    return $urandom & m[31:0];
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PACKET_RATE:       rate_cfg = value[RATE_W-1:0];
      REG_CYCLES_PER_SECOND: cps_cfg  = value[CPS_W-1:0];
      REG_END_TIME:          end_cfg  = value[FIELD_T_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_event(input sched_event_t ev);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ev;
    do @(posedge clk); while (!in_tready);
    result_q.push_back(predict_event(ev));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_traffic(input int n, input bit with_hold);
    traffic_mode_t mode;
    sched_event_t ev;
    mode = MODE_FILL;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(79) == 0) mode = traffic_mode_t'($urandom_range(2));
      if (mode != MODE_FILL && $urandom_range(99) < 10) ev.current_time = rand_time();
      else ev.current_time = sched_now;
      case (mode)
        MODE_FILL: begin
          ev.birth_gap    = rand_scaled(0, 10);
          ev.burst_length = $urandom | 32'h0800_0000;
        end
        MODE_DRAIN: begin
          ev.birth_gap    = rand_scaled(20, 32);
          ev.burst_length = rand_scaled(0, 10);
        end
        default: begin
          ev.birth_gap    = rand_scaled(0, 32);
          ev.burst_length = rand_scaled(0, 32);
        end
      endcase
      // long output stall while the sender keeps offering items
      if (with_hold && i == n / 3) rx_hold = 3000;
      send_event(ev);
    end
    settle();
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // equal birth and end times: death wins
    send_event(make_event('0, '0, '0));
    send_event(make_event(rand_time(), $urandom, $urandom));
    // saturating sums at the top of the time range
    send_event(make_event(T_MAX, '1, '1));
    send_event(make_event(T_MAX, '0, '0));
    send_event(make_event(T_MAX - 5, 32'd3, 32'd1));
    send_event(make_event(48'd100, 32'd10, 32'd50));
    // equal end time inserted next to an existing one
    send_event(make_event(48'd110, 32'd20, 32'd30));
    send_event(make_event(48'd130, 32'd1000, 32'd0));
    repeat (4) send_event(make_event(sched_now, $urandom, $urandom));
    settle();

    // clamp by end_time, zero rate with junk above the field
    write_reg(REG_END_TIME, 48'd500);
    write_reg(REG_PACKET_RATE, {24'hC3C3C3, 24'd0});
    write_reg(REG_CYCLES_PER_SECOND, {16'hA5A5, 32'd1});
    send_event(make_event(48'd200, 32'd100, 32'd100));
    send_event(make_event(48'd300, 32'd1, 32'hFFFF_FFFF));
    send_event(make_event(sched_now, 32'd0, 32'd0));
    send_event(make_event(sched_now, 32'd7, 32'd9));
    settle();

    write_reg(REG_PACKET_RATE, 48'hFF_FFFF);
    write_reg(REG_CYCLES_PER_SECOND, 48'hFFFF_FFFF);
    write_reg(REG_END_TIME, T_MAX);
    send_event(make_event(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    send_event(make_event(48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    send_event(make_event(sched_now, 32'd1, 32'd1));
    send_event(make_event(sched_now, 32'd2, 32'd2));
    settle();
  endtask

  task automatic test_output_stall();
    write_reg(REG_PACKET_RATE, 48'($urandom_range(1000, 1)));
    write_reg(REG_CYCLES_PER_SECOND, 48'hFFFF_FFFF);
    tx_idle_pct = 13;
    rx_idle_pct = 54;
    run_traffic(PHASE_ITEMS, 1'b1);
  endtask

  task automatic test_input_stall();
    write_reg(REG_PACKET_RATE, 48'hFF_FFFF);
    write_reg(REG_CYCLES_PER_SECOND, 48'($urandom));
    write_reg(REG_END_TIME, sat_time(sched_now, 48'h0000_4000_0000));
    tx_idle_pct = 54;
    rx_idle_pct = 13;
    run_traffic(PHASE_ITEMS, 1'b0);
  endtask

  task automatic test_streaming();
    write_reg(REG_PACKET_RATE, 48'd1);
    write_reg(REG_CYCLES_PER_SECOND, 48'd1000000000);
    write_reg(REG_END_TIME, T_MAX);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(PHASE_ITEMS, 1'b0);
  endtask

  initial begin
    rate_cfg      = PACKET_RATE_RST;
    cps_cfg       = CPS_RST;
    end_cfg       = END_TIME_RST;
    birth_due     = '0;
    birth_pending = 1'b1;
    sched_now     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_output_stall();
    test_input_stall();
    test_streaming();

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### burst_birth_death_scheduler.f
src/bbds_pkg.sv
src/bbds_ram.sv
src/bbds_div.sv
src/burst_birth_death_scheduler.sv
src/bbds_checker.sv
dv/burst_birth_death_scheduler_tb.sv
